// ----- hw/rtl/dcrs_pkg.sv -----
// Shared types and constants for the decimal radix sorter.
package dcrs_pkg;

    localparam int VALUE_W = 16;
    localparam int PASS_W = 3;
    localparam int DIGIT_W = 4;
    localparam int RADIX = 10;

    // x / 10 == (x * 0xCCCD) >> 19 holds for every 16-bit x
    localparam logic [VALUE_W-1:0] RECIP_10 = 16'hCCCD;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT10_W = VALUE_W - 3;

    localparam logic [PASS_W-1:0] PASS_MAX = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic [PASS_W-1:0]  passes;
        logic               final_res;
    } out_t;

    // one stored element: the value and its value divided by the current digit weight
    typedef struct packed {
        logic [VALUE_W-1:0] val;
        logic [VALUE_W-1:0] quot;
    } entry_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_COUNT,
        S_PREFIX,
        S_SCATTER,
        S_EMIT_RD,
        S_EMIT_HOLD
    } state_t;

endpackage

// ----- hw/rtl/decimal_radix_sorter_core.sv -----
// Decimal radix sorter: load, LSD base-ten passes and result streaming.
//
// Usage:
//   item channel (item_valid/item_ready/item): one value per beat. Beats are
//   stored in order; beats past DEPTH are dropped. The beat with item.last set
//   closes the set and starts the sort (its last flag counts even if dropped).
//   result channel (result_valid/result_ready/result): one beat per stored
//   element in ascending order, every beat carrying the pass count, the final
//   beat flagged with final_res.
// Operation:
//   Loading accepts one beat per cycle while item_valid is high. Sorting walks
//   both element banks at one shared read address: each pass is a sortedness
//   scan, a digit count, a prefix sum over the ten digit counts and a stable back-to-front scatter; the
//   closing scan finds the set ascending. Up to five passes for 16-bit values.
//   Each result beat then goes out through S_EMIT_RD and S_EMIT_HOLD, and the
//   hold state stays until result_ready is high.
//   item_ready is low from the last beat until the final result is taken.
// Reset: asynchronous, returns to loading with an empty set. A stalled
//   result beat holds its payload until result_ready rises.
module decimal_radix_sorter_core #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  dcrs_pkg::in_t  item,
    output logic           result_valid,
    input  logic           result_ready,
    output dcrs_pkg::out_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = dcrs_pkg::VALUE_W;
    localparam int QW = dcrs_pkg::QUOT10_W;

    // sequencer
    dcrs_pkg::state_t state_reg, state_next;

    // two element banks; cur_reg selects the one holding the live array
    dcrs_pkg::entry_t mem_a [DEPTH];
    dcrs_pkg::entry_t mem_b [DEPTH];
    dcrs_pkg::entry_t rd_a_reg, rd_b_reg, rd_entry, wr_data;
    logic [AW-1:0]    wr_addr;
    logic             wr_en, wr_bank, wr_a_en, wr_b_en;
    logic             cur_reg;

    // set size and walk counter
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_m1_full;
    logic [AW-1:0] n_m1;
    logic [AW-1:0] idx_reg;
    logic          iss_on_reg, dir_down_reg, iss_end;

    // pipeline: p1 = memory data, p2 = digit
    logic          p1_vld_reg, p1_last_reg;
    logic          p2_vld_reg, p2_last_reg;
    logic [31:0]   prod;
    logic [VW-1:0] val2_reg, quot2_reg;
    logic [QW-1:0] q10_2_reg;
    logic [VW-1:0] q10x10, digit_full;
    logic [dcrs_pkg::DIGIT_W-1:0] digit;

    // sortedness scan
    logic [VW-1:0] prev_reg;
    logic          have_prev_reg, unsorted_reg, unsorted_now;

    // digit histogram
    logic [CW-1:0] counts_reg [dcrs_pkg::RADIX];
    logic [dcrs_pkg::DIGIT_W-1:0] pfx_idx_reg, cnt_idx;
    logic [CW-1:0] acc_reg, cnt_rd, acc_sum, pos_full;

    logic [dcrs_pkg::PASS_W-1:0] pass_cnt_reg;

    // strobes
    logic item_fire, load_wr, start_up, start_down, clr_counts, emit_start;
    logic pass_done, pfx_start, emit_next, run_done, emit_end;

    assign item_fire  = item_valid && item_ready;
    assign n_m1_full  = cnt_reg - CW'(1);
    assign n_m1       = n_m1_full[AW-1:0];
    assign iss_end    = dir_down_reg ? (idx_reg == '0) : (idx_reg == n_m1);
    assign rd_entry   = cur_reg ? rd_b_reg : rd_a_reg;
    assign emit_end   = (idx_reg == n_m1);

    assign unsorted_now = unsorted_reg || (have_prev_reg && (rd_entry.val < prev_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dcrs_pkg::S_LOAD:
            begin
                if (item_fire && item.last)
                    state_next = dcrs_pkg::S_CHECK;
            end
            dcrs_pkg::S_CHECK:
            begin
                if (p1_vld_reg && p1_last_reg)
                    state_next = unsorted_now ? dcrs_pkg::S_COUNT : dcrs_pkg::S_EMIT_RD;
            end
            dcrs_pkg::S_COUNT:
            begin
                if (p2_vld_reg && p2_last_reg)
                    state_next = dcrs_pkg::S_PREFIX;
            end
            dcrs_pkg::S_PREFIX:
            begin
                if (pfx_idx_reg == dcrs_pkg::DIGIT_W'(dcrs_pkg::RADIX - 1))
                    state_next = dcrs_pkg::S_SCATTER;
            end
            dcrs_pkg::S_SCATTER:
            begin
                if (p2_vld_reg && p2_last_reg)
                    state_next = dcrs_pkg::S_CHECK;
            end
            dcrs_pkg::S_EMIT_RD:
            begin
                state_next = dcrs_pkg::S_EMIT_HOLD;
            end
            dcrs_pkg::S_EMIT_HOLD:
            begin
                if (result_ready)
                    state_next = emit_end ? dcrs_pkg::S_LOAD : dcrs_pkg::S_EMIT_RD;
            end
            default:
            begin
                state_next = dcrs_pkg::S_LOAD;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_ready   = 1'b0;
        result_valid = 1'b0;
        load_wr      = 1'b0;
        start_up     = 1'b0;
        start_down   = 1'b0;
        clr_counts   = 1'b0;
        emit_start   = 1'b0;
        pass_done    = 1'b0;
        pfx_start    = 1'b0;
        emit_next    = 1'b0;
        run_done     = 1'b0;
        case (state_reg)
            dcrs_pkg::S_LOAD:
            begin
                item_ready = 1'b1;
                load_wr    = item_fire && (cnt_reg < CW'(DEPTH));
                start_up   = item_fire && item.last;
            end
            dcrs_pkg::S_CHECK:
            begin
                if (p1_vld_reg && p1_last_reg)
                begin
                    start_up   = unsorted_now;
                    clr_counts = unsorted_now;
                    emit_start = !unsorted_now;
                end
            end
            dcrs_pkg::S_COUNT:
            begin
                pfx_start = p2_vld_reg && p2_last_reg;
            end
            dcrs_pkg::S_PREFIX:
            begin
                start_down = (pfx_idx_reg == dcrs_pkg::DIGIT_W'(dcrs_pkg::RADIX - 1));
            end
            dcrs_pkg::S_SCATTER:
            begin
                pass_done = p2_vld_reg && p2_last_reg;
                start_up  = p2_vld_reg && p2_last_reg;
            end
            dcrs_pkg::S_EMIT_RD:
            begin
            end
            dcrs_pkg::S_EMIT_HOLD:
            begin
                result_valid = 1'b1;
                emit_next    = result_ready && !emit_end;
                run_done     = result_ready && emit_end;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dcrs_pkg::S_LOAD;
        else
            state_reg <= state_next;
    end

    // memory write port: loading into the live bank, scatter into the other
    always_comb
    begin
        wr_en   = 1'b0;
        wr_bank = cur_reg;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = '{val: item.value, quot: item.value};
        if (load_wr)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == dcrs_pkg::S_SCATTER && p2_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_bank = !cur_reg;
            wr_addr = pos_full[AW-1:0];
            wr_data = '{val: val2_reg, quot: {3'b000, q10_2_reg}};
        end
    end

    assign wr_a_en = wr_en && !wr_bank;
    assign wr_b_en = wr_en && wr_bank;

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
            mem_a[wr_addr] <= wr_data;
        rd_a_reg <= mem_a[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
            mem_b[wr_addr] <= wr_data;
        rd_b_reg <= mem_b[idx_reg];
    end

    // set size, bank select, pass count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cur_reg      <= 1'b0;
            pass_cnt_reg <= '0;
        end
        else
        begin
            if (load_wr)
                cnt_reg <= cnt_reg + CW'(1);
            else if (run_done)
                cnt_reg <= '0;
            if (pass_done)
                cur_reg <= !cur_reg;
            if (pass_done && pass_cnt_reg != dcrs_pkg::PASS_MAX)
                pass_cnt_reg <= pass_cnt_reg + dcrs_pkg::PASS_W'(1);
            else if (run_done)
                pass_cnt_reg <= '0;
        end
    end

    // address walker: up for scan/count/emit, down for scatter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            iss_on_reg   <= 1'b0;
            dir_down_reg <= 1'b0;
        end
        else if (start_up)
        begin
            idx_reg      <= '0;
            iss_on_reg   <= 1'b1;
            dir_down_reg <= 1'b0;
        end
        else if (start_down)
        begin
            idx_reg      <= n_m1;
            iss_on_reg   <= 1'b1;
            dir_down_reg <= 1'b1;
        end
        else if (emit_start)
        begin
            idx_reg <= '0;
        end
        else if (emit_next)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        else if (iss_on_reg)
        begin
            if (iss_end)
                iss_on_reg <= 1'b0;
            else if (dir_down_reg)
                idx_reg <= idx_reg - AW'(1);
            else
                idx_reg <= idx_reg + AW'(1);
        end
    end

    // pipeline valids; the digit stage only runs for count and scatter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            p1_last_reg <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p2_last_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg  <= iss_on_reg;
            p1_last_reg <= iss_end;
            p2_vld_reg  <= p1_vld_reg && (state_reg == dcrs_pkg::S_COUNT ||
                                          state_reg == dcrs_pkg::S_SCATTER);
            p2_last_reg <= p1_last_reg;
        end
    end

    // shared digit unit: quotient / 10 by reciprocal, digit is the remainder
    assign prod = 32'(rd_entry.quot) * 32'(dcrs_pkg::RECIP_10);

    always_ff @(posedge clk)
    begin
        val2_reg  <= rd_entry.val;
        quot2_reg <= rd_entry.quot;
        q10_2_reg <= prod[dcrs_pkg::RECIP_SHIFT +: QW];
    end

    assign q10x10     = {q10_2_reg, 3'b000} + {2'b00, q10_2_reg, 1'b0};
    assign digit_full = quot2_reg - q10x10;
    assign digit      = digit_full[dcrs_pkg::DIGIT_W-1:0];

    // ascending scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            unsorted_reg  <= 1'b0;
        end
        else if (start_up)
        begin
            have_prev_reg <= 1'b0;
            unsorted_reg  <= 1'b0;
        end
        else if (state_reg == dcrs_pkg::S_CHECK && p1_vld_reg)
        begin
            have_prev_reg <= 1'b1;
            unsorted_reg  <= unsorted_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dcrs_pkg::S_CHECK && p1_vld_reg)
            prev_reg <= rd_entry.val;
    end

    // histogram, running prefix sum, scatter slot
    assign cnt_idx  = (state_reg == dcrs_pkg::S_PREFIX) ? pfx_idx_reg : digit;
    assign cnt_rd   = counts_reg[cnt_idx];
    assign acc_sum  = acc_reg + cnt_rd;
    assign pos_full = cnt_rd - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcrs_pkg::RADIX; i++)
                counts_reg[i] <= '0;
            pfx_idx_reg <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (clr_counts)
            begin
                for (int i = 0; i < dcrs_pkg::RADIX; i++)
                    counts_reg[i] <= '0;
            end
            else if (state_reg == dcrs_pkg::S_COUNT && p2_vld_reg)
            begin
                counts_reg[cnt_idx] <= cnt_rd + CW'(1);
            end
            else if (state_reg == dcrs_pkg::S_PREFIX)
            begin
                counts_reg[cnt_idx] <= acc_sum;
            end
            else if (state_reg == dcrs_pkg::S_SCATTER && p2_vld_reg)
            begin
                counts_reg[cnt_idx] <= pos_full;
            end

            if (pfx_start)
            begin
                pfx_idx_reg <= '0;
                acc_reg     <= '0;
            end
            else if (state_reg == dcrs_pkg::S_PREFIX)
            begin
                pfx_idx_reg <= pfx_idx_reg + dcrs_pkg::DIGIT_W'(1);
                acc_reg     <= acc_sum;
            end
        end
    end

    // result beat comes straight from the registered read of the held address
    assign result.sorted_value = rd_entry.val;
    assign result.passes       = pass_cnt_reg;
    assign result.final_res    = emit_end;

endmodule

// ----- hw/rtl/dcrs_checker.sv -----
// Port-level checks for the decimal radix sorter, bound to the top level.
module dcrs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_valid,
    input logic           item_ready,
    input dcrs_pkg::in_t  item,
    input logic           result_valid,
    input logic           result_ready,
    input dcrs_pkg::out_t result
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(result_valid && item_ready))
        else $error("item_ready while a result beat is shown");

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // 16-bit values need at most five decimal passes
    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.passes <= 3'd5)
        else $error("pass count out of range");

    // closing beat ends loading
    a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last |=> !item_ready)
        else $error("still loading after the last beat");

    // final result returns the block to loading
    a_final_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.final_res |=> item_ready && !result_valid)
        else $error("not back to loading after the final result");

endmodule

bind decimal_radix_sorter_core dcrs_checker u_dcrs_checker (.*);

// ----- bench/decimal_radix_sorter_core_test.sv -----
// Self-checking bench for decimal_radix_sorter_core: stimulus, sort predictor and result checks.
module decimal_radix_sorter_core_test;

    localparam int DEPTH = 64;
    // worst case is far below this: ~450 beats, a few full sets, plus stalls on both channels
    localparam int CYCLE_LIMIT = 400000;
    // block has no beat that ends in silence once the last result is out, so a short
    // drain is enough to catch any stray result beat
    localparam int DRAIN_CYCLES = 300;

    // directed stimulus row: one item beat, optionally with a hand-written result
    typedef struct {
        dcrs_pkg::in_t  beat;
        bit             typed;
        dcrs_pkg::out_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    dcrs_pkg::in_t  item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    dcrs_pkg::out_t result;

    // idle percentages for the current phase
    int snd_idle_pct = 20;
    int rcv_idle_pct = 46;

    // predictor state: the set being loaded
    logic [dcrs_pkg::VALUE_W-1:0] held_vals [DEPTH];
    int held_n = 0;

    // expected result beats, oldest first
    dcrs_pkg::out_t pending_sorted [$];

    stim_row_t directed_rows [$];

    int mismatches = 0;
    int cycles = 0;
    int stored_beats = 0;
    int dropped_beats = 0;
    int sets_closed = 0;
    int beats_checked = 0;
    int deepest_pass = 0;

    decimal_radix_sorter_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always #2 clk = ~clk;

    // Run watchdog: a hang or a lost result beat ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result beats still owed",
                     cycles, pending_sorted.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        $display("[%0d] mismatch: %s", cycles, what);
        mismatches++;
    endtask

    // Predictor. Stores each accepted beat (up to DEPTH), and on the beat with
    // last set runs LSD base-ten passes until the set is ascending, then queues
    // one expected result beat per stored element.
    task automatic predict_sorted_run(dcrs_pkg::in_t b, bit typed, dcrs_pkg::out_t want);
        logic [dcrs_pkg::VALUE_W-1:0] scratch [DEPTH];
        int tally [dcrs_pkg::RADIX];
        int pass_n;
        longint unsigned weight;
        int d;
        bit ascending;
        dcrs_pkg::out_t beat;

        if (held_n < DEPTH)
        begin
            held_vals[held_n] = b.value;
            held_n++;
            stored_beats++;
        end
        else
        begin
            // overflow: value is lost, but a last flag still closes the set
            dropped_beats++;
        end

        if (b.last)
        begin
            pass_n = 0;
            weight = 1;
            forever
            begin
                // each pass opens with a sortedness scan
                ascending = 1'b1;
                for (int q = 0; q + 1 < held_n; q++)
                    if (held_vals[q] > held_vals[q + 1])
                        ascending = 1'b0;
                if (ascending || weight > 64'd10000000000)
                    break;

                // digit histogram, prefix sums, then a stable back-to-front scatter
                tally = '{default: 0};
                for (int q = 0; q < held_n; q++)
                begin
                    d = int'((held_vals[q] / weight) % dcrs_pkg::RADIX);
                    tally[d]++;
                end
                for (int q = 1; q < dcrs_pkg::RADIX; q++)
                    tally[q] += tally[q - 1];
                for (int q = held_n - 1; q >= 0; q--)
                begin
                    d = int'((held_vals[q] / weight) % dcrs_pkg::RADIX);
                    tally[d]--;
                    scratch[tally[d]] = held_vals[q];
                end
                for (int q = 0; q < held_n; q++)
                    held_vals[q] = scratch[q];
                weight *= dcrs_pkg::RADIX;
                if (pass_n < dcrs_pkg::PASS_MAX)
                    pass_n++;
            end

            if (pass_n > deepest_pass)
                deepest_pass = pass_n;

            for (int q = 0; q < held_n; q++)
            begin
                beat.sorted_value = held_vals[q];
                beat.passes = pass_n[dcrs_pkg::PASS_W-1:0];
                beat.final_res = (q == held_n - 1);
                pending_sorted.push_back(typed ? want : beat);
            end
            held_n = 0;
            sets_closed++;
        end
    endtask

    // Item side: optional idle gap, then hold valid until the beat is taken.
    // Valid is left high on acceptance; the next call decides whether it drops.
    task automatic send_beat(dcrs_pkg::in_t b, bit typed, dcrs_pkg::out_t want);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_sorted_run(b, typed, want);
    endtask

    // One set of n values; kind picks the value pattern.
    task automatic send_set(int n, int kind);
        logic [dcrs_pkg::VALUE_W-1:0] vals [$];
        logic [dcrs_pkg::VALUE_W-1:0] pool [3];
        int run;
        int k;
        dcrs_pkg::in_t b;

        run = $urandom_range(0, 2000);
        for (int q = 0; q < 3; q++)
            pool[q] = dcrs_pkg::VALUE_W'($urandom_range(0, 65535));
        for (int q = 0; q < n; q++)
        begin
            case (kind)
                0: vals.push_back(dcrs_pkg::VALUE_W'($urandom_range(0, 65535)));
                1: vals.push_back(dcrs_pkg::VALUE_W'($urandom_range(0, 99)));
                2, 3:
                begin
                    // monotonic run, clamped at full scale
                    run += $urandom_range(0, 3000);
                    if (run > 65535)
                        run = 65535;
                    vals.push_back(dcrs_pkg::VALUE_W'(run));
                end
                4: vals.push_back(pool[$urandom_range(0, 2)]);
                default:
                begin
                    // walking one / walking zero
                    k = $urandom_range(0, dcrs_pkg::VALUE_W - 1);
                    if ($urandom_range(0, 1))
                        vals.push_back(dcrs_pkg::VALUE_W'(1) << k);
                    else
                        vals.push_back(~(dcrs_pkg::VALUE_W'(1) << k));
                end
            endcase
        end
        if (kind == 3)
            vals.reverse();
        for (int q = 0; q < n; q++)
        begin
            b.value = vals[q];
            b.last = (q == n - 1);
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic add_row(logic [dcrs_pkg::VALUE_W-1:0] v, logic l, bit typed,
                           dcrs_pkg::out_t want);
        stim_row_t r;
        r.beat.value = v;
        r.beat.last = l;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    // Result side: check every taken beat against the oldest expectation,
    // then pick ready for the next edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending_sorted.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat value=%0d",
                                              result.sorted_value));
                end
                else
                begin
                    dcrs_pkg::out_t exp_beat;
                    exp_beat = pending_sorted.pop_front();
                    if (result.sorted_value !== exp_beat.sorted_value)
                        report_mismatch($sformatf("sorted_value got %0d want %0d",
                                                  result.sorted_value,
                                                  exp_beat.sorted_value));
                    if (result.passes !== exp_beat.passes)
                        report_mismatch($sformatf("passes got %0d want %0d",
                                                  result.passes, exp_beat.passes));
                    if (result.final_res !== exp_beat.final_res)
                        report_mismatch($sformatf("final_res got %0b want %0b",
                                                  result.final_res, exp_beat.final_res));
                end
                beats_checked++;
            end
            result_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        int target;
        int n;
        dcrs_pkg::in_t b;

        // Directed rows. Single-element sets carry their result by hand:
        // the value itself, no passes, flagged final.
        add_row(16'd0, 1'b1, 1'b1, '{sorted_value: 16'd0, passes: 3'd0, final_res: 1'b1});
        add_row(16'd65535, 1'b1, 1'b1,
                '{sorted_value: 16'd65535, passes: 3'd0, final_res: 1'b1});
        // already ascending extremes: no pass
        add_row(16'd0, 1'b0, 1'b0, '0);
        add_row(16'd65535, 1'b1, 1'b0, '0);
        // reversed extremes
        add_row(16'd65535, 1'b0, 1'b0, '0);
        add_row(16'd0, 1'b1, 1'b0, '0);
        // top digit alone decides: needs all five passes
        add_row(16'd10000, 1'b0, 1'b0, '0);
        add_row(16'd9999, 1'b1, 1'b0, '0);
        // all equal
        add_row(16'd7, 1'b0, 1'b0, '0);
        add_row(16'd7, 1'b0, 1'b0, '0);
        add_row(16'd7, 1'b1, 1'b0, '0);
        // duplicates across passes, exercises stability
        add_row(16'd10, 1'b0, 1'b0, '0);
        add_row(16'd1, 1'b0, 1'b0, '0);
        add_row(16'd10, 1'b0, 1'b0, '0);
        add_row(16'd1, 1'b1, 1'b0, '0);
        add_row(16'd21, 1'b0, 1'b0, '0);
        add_row(16'd12, 1'b0, 1'b0, '0);
        add_row(16'd3, 1'b1, 1'b0, '0);
        for (int q = 9; q >= 5; q--)
            add_row(dcrs_pkg::VALUE_W'(q), (q == 5), 1'b0, '0);
        add_row(16'd32768, 1'b1, 1'b1,
                '{sorted_value: 16'd32768, passes: 3'd0, final_res: 1'b1});

        // reset: held low from the start, released on an edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // Random sets in three idling mixes. Each phase opens with a full or
        // overflowing set (65: last beat dropped, 67: three dropped), then
        // mostly small sets.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 20;
                    rcv_idle_pct = 46;
                end
                1:
                begin
                    snd_idle_pct = 46;
                    rcv_idle_pct = 20;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            send_set((phase == 0) ? DEPTH : DEPTH + 1 + 2 * (phase - 1), 0);
            target = stored_beats + 70;
            while (stored_beats < target)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                : $urandom_range(1, 12);
                send_set(n, $urandom_range(0, 5));
            end
        end

        // one lone beat of a random value as a closing set, then let go of the channel
        b.value = dcrs_pkg::VALUE_W'($urandom_range(0, 65535));
        b.last = 1'b1;
        send_beat(b, 1'b0, '0);
        item_valid <= 1'b0;

        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d sets sorted, %0d result beats checked, up to %0d digit passes",
                 sets_closed, beats_checked, deepest_pass);
        $display("%0d overflow beats dropped; idling on item side, result side and neither",
                 dropped_beats);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dcrs_pkg.sv
hw/rtl/decimal_radix_sorter_core.sv
hw/rtl/dcrs_checker.sv
bench/decimal_radix_sorter_core_test.sv
